// ===== hw/rtl/aibd_pkg.sv =====
// ALU instruction byte decoder: shared types, constants and decode helpers.
// No dependencies; used by aibd_front, aibd_queue, aibd_back and the top level.
`default_nettype none

package aibd_pkg;

  localparam logic [7:0] GrpByteImm8  = 8'd128;
  localparam logic [7:0] GrpWordImm16 = 8'd129;
  localparam logic [7:0] GrpWordImm8  = 8'd131;
  localparam logic [7:0] AluOpSpan    = 8'd56;

  localparam logic [1:0] ModNoDisp  = 2'd0;
  localparam logic [1:0] ModDisp8   = 2'd1;
  localparam logic [1:0] ModDisp16  = 2'd2;
  localparam logic [2:0] RmDirect   = 3'd6;

  typedef enum logic [2:0] {
    PhOpcode,
    PhModrm,
    PhDispLo,
    PhDispHi,
    PhImmLo,
    PhImmHi
  } phase_e;

  typedef enum logic [1:0] {
    FormRegMem,
    FormAccImm,
    FormGroup
  } form_e;

  typedef struct packed {
    logic        recognized;
    logic [7:0]  opcode;
    logic [7:0]  modrm;
    logic [15:0] disp;
    logic [15:0] imm;
    logic [2:0]  length;
  } instr_rec_t;

  function automatic logic is_group(input logic [7:0] b);
    return (b == GrpByteImm8) || (b == GrpWordImm16) || (b == GrpWordImm8);
  endfunction

  function automatic logic known_opcode(input logic [7:0] b);
    return ((b <= (AluOpSpan + 8'd7)) && (b[2:0] <= 3'd5)) || is_group(b);
  endfunction

  function automatic form_e form_of(input logic [7:0] b);
    if (is_group(b)) begin
      return FormGroup;
    end
    return (b[2:0] < 3'd4) ? FormRegMem : FormAccImm;
  endfunction

  // number of displacement bytes implied by a ModR/M byte
  function automatic logic [1:0] disp_bytes(input logic [7:0] modrm);
    logic [1:0] n;
    case (modrm[7:6])
      ModNoDisp: n = (modrm[2:0] == RmDirect) ? 2'd2 : 2'd0;
      ModDisp8:  n = 2'd1;
      ModDisp16: n = 2'd2;
      default:   n = 2'd0;
    endcase
    return n;
  endfunction

  // number of immediate bytes implied by an opcode
  function automatic logic [1:0] imm_bytes(input logic [7:0] b);
    logic [1:0] n;
    case (form_of(b))
      FormAccImm: n = b[0] ? 2'd2 : 2'd1;
      FormGroup:  n = (b == GrpWordImm16) ? 2'd2 : 2'd1;
      default:    n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/aibd_front.sv =====
// Front end: takes code bytes, tracks the decode phase and assembles one
// instruction record per finished instruction or skipped byte. Uses aibd_pkg.
`default_nettype none

module aibd_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 byte_valid_i,
  input  wire logic [7:0]           byte_i,
  output logic                      byte_ready_o,
  input  wire logic                 q_full_i,
  output logic                      push_o,
  output aibd_pkg::instr_rec_t      rec_o
);

  aibd_pkg::phase_e phase_q, phase_d;
  logic [7:0]  op_q, op_d;
  logic [7:0]  modrm_q, modrm_d;
  logic [15:0] disp_q, disp_d;
  logic [15:0] imm_q, imm_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        acc;
  logic        has_imm;

  assign byte_ready_o = !q_full_i;
  assign acc          = byte_valid_i && byte_ready_o;
  assign has_imm      = (aibd_pkg::imm_bytes(op_q) != 2'd0);

  always_comb begin
    phase_d = phase_q;
    if (acc) begin
      case (phase_q)
        aibd_pkg::PhModrm: begin
          if (aibd_pkg::disp_bytes(byte_i) != 2'd0) phase_d = aibd_pkg::PhDispLo;
          else if (has_imm) phase_d = aibd_pkg::PhImmLo;
          else phase_d = aibd_pkg::PhOpcode;
        end
        aibd_pkg::PhDispLo: begin
          if (aibd_pkg::disp_bytes(modrm_q) == 2'd2) phase_d = aibd_pkg::PhDispHi;
          else if (has_imm) phase_d = aibd_pkg::PhImmLo;
          else phase_d = aibd_pkg::PhOpcode;
        end
        aibd_pkg::PhDispHi: begin
          phase_d = has_imm ? aibd_pkg::PhImmLo : aibd_pkg::PhOpcode;
        end
        aibd_pkg::PhImmLo: begin
          phase_d = (aibd_pkg::imm_bytes(op_q) == 2'd2) ? aibd_pkg::PhImmHi
                                                        : aibd_pkg::PhOpcode;
        end
        aibd_pkg::PhImmHi: begin
          phase_d = aibd_pkg::PhOpcode;
        end
        default: begin
          if (!aibd_pkg::known_opcode(byte_i)) phase_d = aibd_pkg::PhOpcode;
          else if (aibd_pkg::form_of(byte_i) == aibd_pkg::FormAccImm) begin
            phase_d = aibd_pkg::PhImmLo;
          end else begin
            phase_d = aibd_pkg::PhModrm;
          end
        end
      endcase
    end
  end

  always_comb begin
    op_d    = op_q;
    modrm_d = modrm_q;
    disp_d  = disp_q;
    imm_d   = imm_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    rec_o   = '0;
    if (acc) begin
      cnt_d = cnt_q + 3'd1;
      case (phase_q)
        aibd_pkg::PhModrm: begin
          modrm_d = byte_i;
          push_o  = (aibd_pkg::disp_bytes(byte_i) == 2'd0) && !has_imm;
        end
        aibd_pkg::PhDispLo: begin
          disp_d = {8'd0, byte_i};
          push_o = (aibd_pkg::disp_bytes(modrm_q) != 2'd2) && !has_imm;
        end
        aibd_pkg::PhDispHi: begin
          disp_d = disp_q | {byte_i, 8'd0};
          push_o = !has_imm;
        end
        aibd_pkg::PhImmLo: begin
          imm_d  = {8'd0, byte_i};
          push_o = (aibd_pkg::imm_bytes(op_q) != 2'd2);
        end
        aibd_pkg::PhImmHi: begin
          imm_d  = imm_q | {byte_i, 8'd0};
          push_o = 1'b1;
        end
        default: begin
          if (aibd_pkg::known_opcode(byte_i)) begin
            op_d    = byte_i;
            modrm_d = '0;
            disp_d  = '0;
            imm_d   = '0;
            cnt_d   = 3'd1;
          end else begin
            cnt_d  = '0;
            push_o = 1'b1;
          end
        end
      endcase
      if (phase_q == aibd_pkg::PhModrm || phase_q == aibd_pkg::PhDispLo ||
          phase_q == aibd_pkg::PhDispHi || phase_q == aibd_pkg::PhImmLo ||
          phase_q == aibd_pkg::PhImmHi) begin
        rec_o.recognized = 1'b1;
        rec_o.opcode     = op_d;
        rec_o.modrm      = modrm_d;
        rec_o.disp       = disp_d;
        rec_o.imm        = imm_d;
        rec_o.length     = cnt_d;
      end else begin
        rec_o.length = 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= aibd_pkg::PhOpcode;
      op_q    <= '0;
      modrm_q <= '0;
      disp_q  <= '0;
      imm_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      op_q    <= op_d;
      modrm_q <= modrm_d;
      disp_q  <= disp_d;
      imm_q   <= imm_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/aibd_queue.sv =====
// Short FIFO of instruction records between front and back end.
// Uses aibd_pkg for the record type.
`default_nettype none

module aibd_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire aibd_pkg::instr_rec_t push_rec_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      empty_o,
  output aibd_pkg::instr_rec_t      pop_rec_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  aibd_pkg::instr_rec_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_rec_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    if (do_pop) rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/aibd_back.sv =====
// Back end: turns a queued instruction record into the result fields and
// holds them in the output register. Uses aibd_pkg.
`default_nettype none

module aibd_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_empty_i,
  input  wire aibd_pkg::instr_rec_t rec_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      recognized_o,
  output logic [2:0]                alu_op_o,
  output logic [1:0]                form_o,
  output logic                      is_word_o,
  output logic                      to_register_o,
  output logic [1:0]                mode_bits_o,
  output logic [2:0]                rm_bits_o,
  output logic [2:0]                reg_bits_o,
  output logic [15:0]               displacement_o,
  output logic [15:0]               immediate_o,
  output logic [2:0]                length_o
);

  logic        valid_q, valid_d;
  logic        recog_q, recog_d;
  logic [2:0]  op_q, op_d;
  logic [1:0]  form_q, form_d;
  logic        word_q, word_d;
  logic        toreg_q, toreg_d;
  logic [1:0]  mod_q, mod_d;
  logic [2:0]  rm_q, rm_d;
  logic [2:0]  reg_q, reg_d;
  logic [15:0] disp_q, disp_d;
  logic [15:0] imm_q, imm_d;
  logic [2:0]  len_q, len_d;
  aibd_pkg::form_e f;

  assign pop_o   = !q_empty_i && (!valid_q || out_ready_i);
  assign f       = aibd_pkg::form_of(rec_i.opcode);
  assign valid_d = pop_o || (valid_q && !out_ready_i);

  always_comb begin
    recog_d = rec_i.recognized;
    form_d  = f;
    disp_d  = rec_i.disp;
    len_d   = rec_i.length;
    if (f == aibd_pkg::FormGroup) begin
      op_d   = rec_i.modrm[5:3];
      word_d = (rec_i.opcode != aibd_pkg::GrpByteImm8);
    end else begin
      op_d   = rec_i.opcode[5:3];
      word_d = rec_i.opcode[0];
    end
    toreg_d = (f == aibd_pkg::FormRegMem) ? rec_i.opcode[1] : 1'b0;
    if (f != aibd_pkg::FormAccImm) begin
      mod_d = rec_i.modrm[7:6];
      rm_d  = rec_i.modrm[2:0];
      reg_d = rec_i.modrm[5:3];
    end else begin
      mod_d = '0;
      rm_d  = '0;
      reg_d = '0;
    end
    imm_d = (f == aibd_pkg::FormRegMem) ? 16'd0 : rec_i.imm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      recog_q <= recog_d;
      op_q    <= op_d;
      form_q  <= form_d;
      word_q  <= word_d;
      toreg_q <= toreg_d;
      mod_q   <= mod_d;
      rm_q    <= rm_d;
      reg_q   <= reg_d;
      disp_q  <= disp_d;
      imm_q   <= imm_d;
      len_q   <= len_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign recognized_o   = recog_q;
  assign alu_op_o       = op_q;
  assign form_o         = form_q;
  assign is_word_o      = word_q;
  assign to_register_o  = toreg_q;
  assign mode_bits_o    = mod_q;
  assign rm_bits_o      = rm_q;
  assign reg_bits_o     = reg_q;
  assign displacement_o = disp_q;
  assign immediate_o    = imm_q;
  assign length_o       = len_q;

endmodule

`default_nettype wire

// ===== hw/rtl/alu_instruction_byte_decoder_top.sv =====
// ALU instruction byte decoder, top level.
// Instantiates aibd_front, aibd_queue and aibd_back; uses aibd_pkg.
//
// Input channel: one code byte per transfer (code_byte_i, in_valid_i/in_ready_o).
// Output channel: one result per finished instruction or skipped byte
// (out_valid_o/out_ready_i plus the result fields).
// Throughput: one byte per cycle while the queue is not full; the front
// end assembles the instruction, the back end formats it and the output
// register holds it. The record of the last byte of an instruction (or of
// a skipped byte) is written into the queue at its transfer; the back end
// pops it into the output register once that register is empty or taken.
// Stall: while out_ready_i is low the queue fills; once it holds QueueDepth
// records in_ready_o drops until the receiver takes a result.
// Reset: the decoder waits for an opcode, queue and output are empty.
`default_nettype none

module alu_instruction_byte_decoder_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  code_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             recognized_o,
  output logic [2:0]       alu_op_o,
  output logic [1:0]       form_o,
  output logic             is_word_o,
  output logic             to_register_o,
  output logic [1:0]       mode_bits_o,
  output logic [2:0]       rm_bits_o,
  output logic [2:0]       reg_bits_o,
  output logic [15:0]      displacement_o,
  output logic [15:0]      immediate_o,
  output logic [2:0]       length_o
);

  aibd_pkg::instr_rec_t push_rec, pop_rec;
  logic push, pop, q_full, q_empty;

  aibd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_valid_i),
    .byte_i       (code_byte_i),
    .byte_ready_o (in_ready_o),
    .q_full_i     (q_full),
    .push_o       (push),
    .rec_o        (push_rec)
  );

  aibd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .pop_rec_o  (pop_rec)
  );

  aibd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .rec_i          (pop_rec),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .recognized_o   (recognized_o),
    .alu_op_o       (alu_op_o),
    .form_o         (form_o),
    .is_word_o      (is_word_o),
    .to_register_o  (to_register_o),
    .mode_bits_o    (mode_bits_o),
    .rm_bits_o      (rm_bits_o),
    .reg_bits_o     (reg_bits_o),
    .displacement_o (displacement_o),
    .immediate_o    (immediate_o),
    .length_o       (length_o)
  );

endmodule

`default_nettype wire
